/* rtl/core/biss_pkg.sv */
// Package: command codes and beat structs for the bounded sorted stack
`default_nettype none
package biss_pkg;
    localparam int unsigned KIND_BITS = 3;
    localparam int unsigned CAP_BITS  = 7;
    localparam int unsigned POS_BITS  = 6;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_PUSH = 3'd0,
        KIND_POP  = 3'd1,
        KIND_GET  = 3'd2,
        KIND_FIND = 3'd3,
        KIND_SORT = 3'd4
    } kind_t;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic signed [31:0]   value;
        logic [POS_BITS-1:0]  position;
    } cmd_t;

    typedef struct packed {
        logic                ok;
        logic signed [31:0]  data;
        logic [POS_BITS-1:0] found_index;
        logic [CAP_BITS-1:0] length;
        logic                in_order;
    } rsp_t;

    // Per-cycle control broadcast from the sequencer to every cell
    typedef struct packed {
        logic shift_up;   // take the lower neighbor's word (push at 0)
        logic shift_dn;   // take the upper neighbor's word (pop / scan rotate)
        logic swap;       // odd-even transposition compare-exchange
        logic odd_phase;  // which pairs swap this cycle
    } cell_ctl_t;
endpackage
`default_nettype wire

/* rtl/core/bounded_int_stack_sort_search_top.sv */
// Top level: chain of word cells plus the command sequencer
`default_nettype none
// Bounded stack of signed words held in a chain of cells, newest word in
// cell 0. A push or pop that succeeds passes through the shift state, then the
// result strobe (done). Get and find rotate the stored words once around past
// the tap at cell 0; the rotation sets their time. Sort runs DEPTH odd-even
// transposition steps in the cells. A failed push or pop, get or find on an
// empty store, get past the end and an unknown kind go straight to the
// strobe. Every command ends with a one-cycle result strobe, which the
// receiver cannot hold off; busy is high from the accepting edge through the
// strobe cycle.
module bounded_int_stack_sort_search_top #(
    parameter int unsigned DEPTH     = 64,
    parameter int unsigned WORD_BITS = 32
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  wire biss_pkg::cmd_t  cmd,
    output logic                 busy,
    output logic                 done,
    output biss_pkg::rsp_t       rsp,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [6:0]      cfg_data
);
    import biss_pkg::*;

    localparam int unsigned IB = $clog2(DEPTH);

    typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_SCAN, S_SORT, S_DONE} state_t;

    state_t               state_reg;
    logic [6:0]           cap_reg;
    logic [IB:0]          count_reg;
    logic [IB:0]          step_reg;
    cmd_t                 cmd_reg;
    rsp_t                 rsp_reg;
    rsp_t                 rsp_next;
    logic                 hit_reg;
    logic [IB-1:0]        hit_idx_reg;
    logic [WORD_BITS-1:0] tap_reg;
    cell_ctl_t            ctl;
    logic [WORD_BITS-1:0] words [DEPTH];
    logic [WORD_BITS-1:0] lo_in [DEPTH];
    logic [WORD_BITS-1:0] hi_in [DEPTH];
    logic [WORD_BITS-1:0] val_w;
    logic [IB:0]          usable;
    logic [IB:0]          cur_idx;
    logic                 ordered;
    logic [DEPTH-1:0]     desc;

    assign val_w  = WORD_BITS'(cmd_reg.value);
    assign usable = (32'(cap_reg) > DEPTH) ? (IB+1)'(DEPTH) : (IB+1)'(cap_reg);
    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_DONE;
    assign cfg_ready = !busy;
    // Logical index sitting in cell 0 after step_reg rotations
    assign cur_idx = (count_reg - 1'b1 - step_reg);

    // Result beat: length and order flag reflect the store as it is now
    always_comb
    begin
        rsp          = rsp_reg;
        rsp.length   = 7'(count_reg);
        rsp.in_order = ordered;
    end

    // Chain wiring: cell k holds stack entry count-1-k; scan rotation wraps
    // cell 0 around into cell count-1
    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            hi_in[k] = (k == DEPTH-1) ? '0 : words[(k+1) % DEPTH];
            lo_in[k] = (k == 0) ? val_w : words[(k+DEPTH-1) % DEPTH];
        end
        if (state_reg == S_SCAN)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                if ((IB+1)'(k) + 1'b1 == count_reg) hi_in[k] = words[0];
            end
        end
    end

    // Neighbor order flags: a pair inside the stack that is descending by index
    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            desc[k] = (k < DEPTH-1) && ((IB+1)'(k) + 1'b1 < count_reg)
                      && ($signed(words[k]) < $signed(words[(k+1) % DEPTH]));
        end
        ordered = desc == '0;
    end

    // Cell control: push/pop shift, scan rotate from upper neighbor, sort swap
    always_comb
    begin
        ctl = '0;
        ctl.odd_phase = step_reg[0];
        unique case (state_reg)
            S_SHIFT:
            begin
                ctl.shift_up = cmd_reg.kind == KIND_PUSH;
                ctl.shift_dn = cmd_reg.kind == KIND_POP;
            end
            S_SCAN:  ctl.shift_dn = 1'b1;
            S_SORT:  ctl.swap = 1'b1;
            default: ctl = '0;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            cell_ctl_t c;
            always_comb
            begin
                c = ctl;
                // cells above the stack stay put during rotation
                if (state_reg == S_SCAN && (IB+1)'(g) >= count_reg) c.shift_dn = 1'b0;
            end
            biss_cell #(.WORD_BITS(WORD_BITS), .IDX_BITS(IB), .IDX(g)) u_cell (
                .clk(clk), .ctl(c), .count(count_reg),
                .from_lo(lo_in[g]),
                .from_hi(hi_in[g]),
                .word(words[g])
            );
        end
    endgenerate

    // Next result: set up at accept, completed on the last scan step
    always_comb
    begin
        rsp_next = rsp_reg;
        if (state_reg == S_IDLE && start)
        begin
            rsp_next = '0;
            case (cmd.kind)
                KIND_PUSH: rsp_next.ok = count_reg < usable;
                KIND_POP:
                begin
                    if (count_reg != '0)
                    begin
                        rsp_next.ok   = 1'b1;
                        rsp_next.data = 32'($signed(words[0]));
                    end
                end
                default: ;
            endcase
        end
        else if (state_reg == S_SCAN && step_reg + 1'b1 == count_reg)
        begin
            // final hit includes this cycle's compare
            if (cmd_reg.kind == KIND_GET)
            begin
                if (hit_reg || (IB+1)'(cmd_reg.position) == cur_idx)
                begin
                    rsp_next.ok   = 1'b1;
                    rsp_next.data = 32'($signed(
                        ((IB+1)'(cmd_reg.position) == cur_idx) ? words[0] : tap_reg));
                end
            end
            else if (hit_reg || words[0] == val_w)
            begin
                rsp_next.ok = 1'b1;
                rsp_next.found_index = POS_BITS'(
                    (words[0] == val_w) ? cur_idx[IB-1:0] : hit_idx_reg);
            end
        end
    end

    // Sequencer: state, count, registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cap_reg     <= 7'd64;
            count_reg   <= '0;
            step_reg    <= '0;
            hit_reg     <= 1'b0;
            hit_idx_reg <= '0;
            cmd_reg     <= '0;
            rsp_reg     <= '0;
            tap_reg     <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready) cap_reg <= cfg_data;
            rsp_reg <= rsp_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg  <= cmd;
                        step_reg <= '0;
                        hit_reg  <= 1'b0;
                        hit_idx_reg <= '0;
                        tap_reg  <= '0;
                        case (cmd.kind)
                            KIND_PUSH:
                                state_reg <= (count_reg < usable) ? S_SHIFT : S_DONE;
                            KIND_POP:
                                state_reg <= (count_reg != '0) ? S_SHIFT : S_DONE;
                            KIND_GET:
                                state_reg <= (32'(cmd.position) < 32'(count_reg))
                                             ? S_SCAN : S_DONE;
                            KIND_FIND:
                                state_reg <= (count_reg == '0) ? S_DONE : S_SCAN;
                            KIND_SORT: state_reg <= S_SORT;
                            default:   state_reg <= S_DONE;
                        endcase
                    end
                end
                S_SHIFT:
                begin
                    count_reg <= (cmd_reg.kind == KIND_PUSH) ? count_reg + 1'b1
                                                             : count_reg - 1'b1;
                    state_reg <= S_DONE;
                end
                S_SCAN:
                begin
                    // cell 0 holds logical index cur_idx this cycle
                    if (cmd_reg.kind == KIND_GET
                        && (IB+1)'(cmd_reg.position) == cur_idx)
                    begin
                        hit_reg <= 1'b1;
                        tap_reg <= words[0];
                    end
                    if (cmd_reg.kind == KIND_FIND && words[0] == val_w)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= cur_idx[IB-1:0];
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg + 1'b1 == count_reg) state_reg <= S_DONE;
                end
                S_SORT:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == (IB+1)'(DEPTH-1)) state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/core/biss_cell.sv */
// One storage cell of the chain: holds one word, shifts and compare-exchanges
`default_nettype none
module biss_cell #(
    parameter int unsigned WORD_BITS = 32,
    parameter int unsigned IDX_BITS  = 6,
    parameter int unsigned IDX       = 0
) (
    input  wire                          clk,
    input  wire biss_pkg::cell_ctl_t     ctl,
    input  wire logic [IDX_BITS:0]       count,
    input  wire logic [WORD_BITS-1:0]    from_lo,
    input  wire logic [WORD_BITS-1:0]    from_hi,
    output logic [WORD_BITS-1:0]         word
);
    import biss_pkg::*;

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic                 hi_gt;   // upper neighbor larger than this word
    logic                 lo_lt;   // lower neighbor smaller than this word
    logic                 is_low;  // lower member of a pair this phase
    logic                 lo_live;
    logic                 hi_live;

    assign word = word_reg;

    // Cell 0 holds the top of the stack, so the chain sorts descending by cell
    assign hi_gt   = $signed(from_hi) > $signed(word_reg);
    assign lo_lt   = $signed(from_lo) < $signed(word_reg);
    assign is_low  = (IDX % 2 == 1) == ctl.odd_phase;
    assign hi_live = ({1'b0, IDX_BITS'(IDX)} + 1'b1) < count;
    assign lo_live = (IDX != 0) && ({1'b0, IDX_BITS'(IDX)} < count);

    // Next word: shift or sort exchange with a neighbor
    always_comb
    begin
        word_next = word_reg;
        if (ctl.shift_up)
        begin
            word_next = from_lo;
        end
        else if (ctl.shift_dn)
        begin
            word_next = from_hi;
        end
        else if (ctl.swap)
        begin
            if (is_low && hi_live && hi_gt)
            begin
                word_next = from_hi;
            end
            else if (!is_low && lo_live && lo_lt)
            begin
                word_next = from_lo;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end
endmodule
`default_nettype wire

/* rtl/core/biss_checker.sv */
// Port-level checker for the bounded sorted stack, bound to the top level
`default_nettype none
module biss_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 start,
    input wire                 busy,
    input wire                 done,
    input wire biss_pkg::rsp_t rsp
);
    import biss_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accepted command did not raise busy");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("result beat while not busy");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result beat repeated");
    a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy) else $error("busy after result beat");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.ok) |-> (rsp.data == '0 && rsp.found_index == '0))
        else $error("failed command carries data");
endmodule

bind bounded_int_stack_sort_search_top biss_checker u_biss_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
`default_nettype wire

/* dv/bounded_int_stack_sort_search_top_tb.sv */
// Testbench for the bounded sorted stack: directed and random commands checked against a predictor
`default_nettype none
module bounded_int_stack_sort_search_top_tb;
    import biss_pkg::*;

    localparam int DEPTH     = 64;
    localparam int WDOG_MAX  = 2000;

    logic       clk;
    logic       rst_n;
    logic       start;
    cmd_t       cmd;
    logic       busy;
    logic       done;
    rsp_t       rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [6:0] cfg_data;

    bounded_int_stack_sort_search_top #(.DEPTH(DEPTH), .WORD_BITS(32)) i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd), .busy(busy), .done(done),
        .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // predictor state
    logic signed [31:0] stack_words [DEPTH];
    int                 stack_fill;
    int                 stack_cap;
    rsp_t               pending_rsp [$];
    int                 err_count = 0;
    int                 idle_cycles = 0;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic bit stack_sorted();
        for (int i = 1; i < stack_fill; i++)
            if (stack_words[i] < stack_words[i-1])
                return 1'b0;
        return 1'b1;
    endfunction

    // compute the expected response and advance the predicted store
    function automatic rsp_t predict_rsp(cmd_t c);
        rsp_t               r;
        int                 lim;
        logic signed [31:0] key;
        int                 j;
        r = '0;
        lim = (stack_cap > DEPTH) ? DEPTH : stack_cap;
        case (c.kind)
            KIND_PUSH:
                if (stack_fill < lim)
                begin
                    stack_words[stack_fill] = c.value;
                    stack_fill++;
                    r.ok = 1'b1;
                end
            KIND_POP:
                if (stack_fill > 0)
                begin
                    stack_fill--;
                    r.data = stack_words[stack_fill];
                    r.ok = 1'b1;
                end
            KIND_GET:
                if (int'(c.position) < stack_fill)
                begin
                    r.data = stack_words[c.position];
                    r.ok = 1'b1;
                end
            KIND_FIND:
                for (int i = 0; i < stack_fill; i++)
                    if (stack_words[i] == c.value)
                    begin
                        r.ok = 1'b1;
                        r.found_index = i[5:0];
                        break;
                    end
            KIND_SORT:
                for (int i = 1; i < stack_fill; i++)
                begin
                    key = stack_words[i];
                    j = i;
                    while (j > 0 && stack_words[j-1] > key)
                    begin
                        stack_words[j] = stack_words[j-1];
                        j--;
                    end
                    stack_words[j] = key;
                end
            default: ;
        endcase
        r.length = stack_fill[6:0];
        r.in_order = stack_sorted();
        return r;
    endfunction

    // send one command beat after a random gap
    task automatic send_cmd(logic [2:0] k, logic signed [31:0] v, logic [5:0] p);
        cmd_t c;
        repeat ($urandom_range(0, 3)) @(posedge clk);
        c.kind = k;
        c.value = v;
        c.position = p;
        start <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (busy);
        pending_rsp.push_back(predict_rsp(c));
        start <= 1'b0;
        // the block is busy for at least this cycle after the beat
        @(posedge clk);
    endtask

    // let the block drain before touching the register
    task automatic wait_drained();
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(int cap);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= cap[6:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        stack_cap = cap;
    endtask

    // result checker
    always @(posedge clk)
    begin
        rsp_t e;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected response %p", $time, rsp);
                err_count++;
            end
            else
            begin
                e = pending_rsp.pop_front();
                if (rsp.ok !== e.ok || rsp.data !== e.data || rsp.found_index !== e.found_index
                    || rsp.length !== e.length || rsp.in_order !== e.in_order)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, e, rsp);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles without an accepted beat, a result or a register write
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $signed(32'($urandom_range(0, 7)) - 32'd4);
            default: return $signed($urandom());
        endcase
    endfunction

    // edge values, every kind, empty cases and get past the end
    task automatic test_directed();
        send_cmd(KIND_POP, 0, 0);
        send_cmd(KIND_GET, 0, 0);
        send_cmd(KIND_FIND, 0, 0);
        send_cmd(KIND_SORT, 0, 0);
        send_cmd(KIND_PUSH, 32'sh7fff_ffff, 6'h3f);
        send_cmd(KIND_PUSH, 32'sh8000_0000, 0);
        send_cmd(KIND_PUSH, -1, 0);
        send_cmd(KIND_PUSH, -1, 0);
        send_cmd(KIND_FIND, -1, 0);
        send_cmd(KIND_FIND, 5, 0);
        send_cmd(KIND_GET, 0, 6'd3);
        send_cmd(KIND_GET, 0, 6'd4);
        send_cmd(KIND_GET, 0, 6'h3f);
        for (int k = 5; k < 8; k++)
            send_cmd(k[2:0], 32'sh5555_aaaa, 6'h2a);
        send_cmd(KIND_SORT, 0, 0);
        send_cmd(KIND_GET, 0, 0);
        send_cmd(KIND_POP, 0, 0);
        send_cmd(KIND_POP, 0, 0);
    endtask

    // capacity extremes: zero, below count, above depth
    task automatic test_capacity();
        write_capacity(0);
        send_cmd(KIND_PUSH, 7, 0);
        send_cmd(KIND_POP, 0, 0);
        write_capacity(127);
        for (int i = 0; i < 66; i++)
            send_cmd(KIND_PUSH, rand_word(), 0);
        send_cmd(KIND_SORT, 0, 0);
        send_cmd(KIND_FIND, 32'sh7fff_ffff, 0);
        send_cmd(KIND_GET, 0, 6'h3f);
        write_capacity(3);
        send_cmd(KIND_PUSH, 1, 0);
        send_cmd(KIND_FIND, rand_word(), 0);
        while (stack_fill > 0)
            send_cmd(KIND_POP, 0, 0);
    endtask

    // random mix, swept over several capacities
    task automatic test_random();
        int   n;
        logic [2:0] k;
        for (int ph = 0; ph < 4; ph++)
        begin
            n = $urandom_range(0, 3);
            write_capacity(n == 0 ? 64 : n == 1 ? 8 : n == 2 ? 1 : $urandom_range(2, 70));
            for (int i = 0; i < 160; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: k = KIND_PUSH;
                    3, 4:    k = KIND_POP;
                    5:       k = KIND_GET;
                    6, 7:    k = KIND_FIND;
                    8:       k = KIND_SORT;
                    default: k = 3'($urandom_range(5, 7));
                endcase
                if (k == KIND_FIND && stack_fill > 0 && $urandom_range(0, 1))
                    send_cmd(k, stack_words[$urandom_range(0, stack_fill - 1)], 6'($urandom()));
                else
                    send_cmd(k, rand_word(), 6'($urandom()));
                if (i == 100)
                    wait_drained();
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        stack_fill = 0;
        stack_cap = 64;
        for (int i = 0; i < DEPTH; i++)
            stack_words[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_capacity();
        test_random();
        wait_drained();
        repeat (DEPTH + 4) @(posedge clk);
        if (err_count == 0 && pending_rsp.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire

/* bounded_int_stack_sort_search_top.f */
rtl/core/biss_pkg.sv
rtl/core/biss_cell.sv
rtl/core/bounded_int_stack_sort_search_top.sv
rtl/core/biss_checker.sv
dv/bounded_int_stack_sort_search_top_tb.sv
